/* src/rlcg48_pkg.sv */
package rlcg48_pkg;

  // Widths fixed by the register and field formats.
  localparam int REG_W       = 48;
  localparam int IDX_W       = 2;
  localparam int DRAW_W      = 32;
  localparam int BOUND_W     = 31;
  localparam int COUNT_W     = 6;
  localparam int RESULT_W    = 64;
  localparam int SEED_BITS_D = 48;

  // Upper end of the draw window inside the seed.
  localparam int WINDOW_TOP = 48;

  // Rejection sampling gives up after this many draws.
  localparam int DRAW_LIMIT = 64;
  localparam int DRAWN_W    = $clog2(DRAW_LIMIT);

  // Register indexes.
  localparam logic [IDX_W-1:0] REG_MULT = 2'd0;
  localparam logic [IDX_W-1:0] REG_INC  = 2'd1;
  localparam logic [IDX_W-1:0] REG_INV  = 2'd2;

  // Register reset values.
  localparam logic [REG_W-1:0] MULT_RESET = 48'd25214903917;
  localparam logic [REG_W-1:0] INC_RESET  = 48'd11;
  localparam logic [REG_W-1:0] INV_RESET  = 48'd246154705703781;

  // Operation codes.
  localparam logic [2:0] OP_SEED_MIX  = 3'd0;
  localparam logic [2:0] OP_SEED_RAW  = 3'd1;
  localparam logic [2:0] OP_NEXT_BITS = 3'd2;
  localparam logic [2:0] OP_PREV_BITS = 3'd3;
  localparam logic [2:0] OP_NEXT_BND  = 3'd4;
  localparam logic [2:0] OP_PREV_BND  = 3'd5;
  localparam logic [2:0] OP_NEXT_LONG = 3'd6;

endpackage

/* src/reversible_lcg48_random_source.sv */
// Seeding, unused codes and non-positive limits go straight from idle to the finishing state.
// A step runs a load state, one shift-add per multiplier bit up to its highest set bit, a state
// that sees the multiplier spent and one that takes the bits. A 64-bit result takes two steps;
// a power-of-two limit adds a scaling state; any other limit runs the serial divider and the
// rejection check per draw, up to 64 draws. One command at a time, next taken while a result waits.
// Reset: synchronous, active high; seed cleared, registers back to their defaults.
module reversible_lcg48_random_source #(
  parameter int SEED_BITS = rlcg48_pkg::SEED_BITS_D
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [rlcg48_pkg::IDX_W-1:0]    cfg_index,
  input  logic [rlcg48_pkg::REG_W-1:0]    cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [2:0]                      operation,
  input  logic [rlcg48_pkg::REG_W-1:0]    seed_value,
  input  logic [rlcg48_pkg::COUNT_W-1:0]  bit_count,
  input  logic signed [rlcg48_pkg::DRAW_W-1:0] limit,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [rlcg48_pkg::RESULT_W-1:0] result_value
);
  import rlcg48_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_MUL, ST_DRAWN, ST_POW, ST_DIV, ST_CHECK, ST_FINISH
  } state_t;

  state_t state;

  logic [REG_W-1:0]     lcg_multiplier;
  logic [REG_W-1:0]     lcg_increment;
  logic [REG_W-1:0]     inverse_multiplier;
  logic [SEED_BITS-1:0] seed;

  logic [2:0]           op_q;
  logic [COUNT_W-1:0]   cnt_q;
  logic [DRAW_W-1:0]    lim_q;
  logic                 half;
  logic [DRAW_W-1:0]    hi_q;
  logic [DRAWN_W-1:0]   draws;

  // Serial multiplier: addend, remaining multiplier bits, accumulator.
  logic [SEED_BITS-1:0] mul_a;
  logic [REG_W-1:0]     mul_m;
  logic [SEED_BITS-1:0] mul_acc;

  // Serial divider.
  logic [DRAW_W-1:0]    j_q;
  logic [DRAW_W-1:0]    div_sh;
  logic [DRAW_W-1:0]    rem;
  logic [5:0]           div_cnt;

  logic [2*DRAW_W-1:0]  prod;
  logic [RESULT_W-1:0]  res;

  // Window of bits taken after a step.
  logic [COUNT_W-1:0]   take_cnt;
  logic [COUNT_W-1:0]   shamt;
  logic [SEED_BITS-1:0] shifted;
  logic [DRAW_W-1:0]    bits;
  logic                 bounded_op;
  logic                 backward;
  logic                 lim_pow2;
  logic [DRAW_W:0]      rem_try;
  logic [DRAW_W:0]      rem_sub;
  logic [DRAW_W-1:0]    chk;

  assign bounded_op = (op_q == OP_NEXT_BND) || (op_q == OP_PREV_BND);
  assign backward   = (op_q == OP_PREV_BITS) || (op_q == OP_PREV_BND);
  assign lim_pow2   = ((lim_q & (lim_q - DRAW_W'(1))) == '0);

  always_comb begin
    if (bounded_op) begin
      take_cnt = COUNT_W'(BOUND_W);
    end else if (op_q == OP_NEXT_LONG || cnt_q > COUNT_W'(DRAW_W)) begin
      take_cnt = COUNT_W'(DRAW_W);
    end else begin
      take_cnt = cnt_q;
    end
    shamt   = COUNT_W'(WINDOW_TOP) - take_cnt;
    shifted = seed >> shamt;
    bits    = shifted[DRAW_W-1:0];
  end

  // Divider step and rejection test.
  assign rem_try = {rem, div_sh[DRAW_W-1]};
  assign rem_sub = rem_try - {1'b0, lim_q};
  assign chk     = j_q - rem + (lim_q - DRAW_W'(1));

  assign in_ready = (state == ST_IDLE);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      lcg_multiplier     <= MULT_RESET;
      lcg_increment      <= INC_RESET;
      inverse_multiplier <= INV_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MULT: lcg_multiplier     <= cfg_data;
        REG_INC:  lcg_increment      <= cfg_data;
        REG_INV:  inverse_multiplier <= cfg_data;
        default: ;
      endcase
    end
  end

  // Command sequencer, datapath and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      seed      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            op_q  <= operation;
            cnt_q <= bit_count;
            lim_q <= limit;
            half  <= 1'b0;
            draws <= '0;
            case (operation)
              OP_SEED_MIX: begin
                seed  <= SEED_BITS'(seed_value ^ lcg_multiplier);
                res   <= '0;
                state <= ST_FINISH;
              end
              OP_SEED_RAW: begin
                seed  <= SEED_BITS'(seed_value);
                res   <= '0;
                state <= ST_FINISH;
              end
              OP_NEXT_BITS, OP_PREV_BITS, OP_NEXT_LONG: state <= ST_LOAD;
              OP_NEXT_BND, OP_PREV_BND: begin
                if (limit[DRAW_W-1] || limit == '0) begin
                  res   <= RESULT_W'(limit);
                  state <= ST_FINISH;
                end else begin
                  state <= ST_LOAD;
                end
              end
              default: begin
                res   <= '0;
                state <= ST_FINISH;
              end
            endcase
          end
        end
        ST_LOAD: begin
          if (backward) begin
            mul_a   <= seed - SEED_BITS'(lcg_increment);
            mul_m   <= inverse_multiplier;
            mul_acc <= '0;
          end else begin
            mul_a   <= seed;
            mul_m   <= lcg_multiplier;
            mul_acc <= SEED_BITS'(lcg_increment);
          end
          state <= ST_MUL;
        end
        ST_MUL: begin
          if (mul_m == '0) begin
            seed  <= mul_acc;
            state <= ST_DRAWN;
          end else begin
            if (mul_m[0]) begin
              mul_acc <= mul_acc + mul_a;
            end
            mul_a <= mul_a << 1;
            mul_m <= mul_m >> 1;
          end
        end
        ST_DRAWN: begin
          if (bounded_op) begin
            // The remainder path works on the low 31 drawn bits only.
            j_q <= {1'b0, bits[BOUND_W-1:0]};
            if (lim_pow2) begin
              prod  <= (2*DRAW_W)'(lim_q) * (2*DRAW_W)'(bits);
              state <= ST_POW;
            end else begin
              div_sh  <= {1'b0, bits[BOUND_W-1:0]};
              rem     <= '0;
              div_cnt <= '0;
              state   <= ST_DIV;
            end
          end else if (op_q == OP_NEXT_LONG && !half) begin
            hi_q  <= bits;
            half  <= 1'b1;
            state <= ST_LOAD;
          end else if (op_q == OP_NEXT_LONG) begin
            res   <= {hi_q, {DRAW_W{1'b0}}} + RESULT_W'($signed(bits));
            state <= ST_FINISH;
          end else begin
            res   <= RESULT_W'($signed(bits));
            state <= ST_FINISH;
          end
        end
        ST_POW: begin
          res   <= RESULT_W'($signed(prod[DRAW_W+BOUND_W-1:BOUND_W]));
          state <= ST_FINISH;
        end
        ST_DIV: begin
          rem     <= rem_sub[DRAW_W] ? rem_try[DRAW_W-1:0] : rem_sub[DRAW_W-1:0];
          div_sh  <= div_sh << 1;
          div_cnt <= div_cnt + 6'(1);
          if (div_cnt == 6'(DRAW_W - 1)) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (!chk[DRAW_W-1] || draws == DRAWN_W'(DRAW_LIMIT - 1)) begin
            res   <= RESULT_W'($signed(rem));
            state <= ST_FINISH;
          end else begin
            draws <= draws + DRAWN_W'(1);
            state <= ST_LOAD;
          end
        end
        ST_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            result_value <= res;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // A step is taken only once every multiplier bit has been consumed.
  a_mul_done: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAWN |-> $past(mul_m) == '0)
    else $error("step finished with multiplier bits left");

  // A transfer in makes the block busy in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second command taken while busy");

  // A result is loaded only from the finishing state.
  a_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FINISH)
    else $error("result shown outside the finishing state");
`endif

endmodule

/* tb/reversible_lcg48_random_source_tb.sv */
`timescale 1ns / 100ps

module reversible_lcg48_random_source_tb;
  import rlcg48_pkg::*;

  localparam int CYCLE_LIMIT = 20000000;
  localparam int HOLD_CYCLES = 800;
  localparam logic [2:0] OP_UNUSED = 3'd7;

  logic                        clk;
  logic                        rst;
  logic                        cfg_write;
  logic [IDX_W-1:0]            cfg_index;
  logic [REG_W-1:0]            cfg_data;
  logic                        in_valid;
  logic                        in_ready;
  logic [2:0]                  operation;
  logic [REG_W-1:0]            seed_value;
  logic [COUNT_W-1:0]          bit_count;
  logic signed [DRAW_W-1:0]    limit;
  logic                        out_valid;
  logic                        out_ready;
  logic signed [RESULT_W-1:0]  result_value;

  // Predictor state: seed and a copy of the three registers.
  logic [REG_W-1:0] pred_seed;
  logic [REG_W-1:0] pred_mult;
  logic [REG_W-1:0] pred_inc;
  logic [REG_W-1:0] pred_inv;

  logic signed [RESULT_W-1:0] expected_values[$];
  int   error_count;
  int   cycle_count;
  bit   gaps_on;
  bit   hold_request;

  reversible_lcg48_random_source i_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .seed_value(seed_value),
    .bit_count(bit_count), .limit(limit),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_value(result_value)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // One step of the generator, returning the top bits of the new seed.
  function automatic logic [31:0] step_draw(bit backward, int unsigned count);
    int unsigned c;
    logic [63:0] wide;
    if (backward)
      pred_seed = (pred_seed - pred_inc) * pred_inv;
    else
      pred_seed = pred_seed * pred_mult + pred_inc;
    c = (count > 32) ? 32 : count;
    wide = {16'b0, pred_seed} >> (48 - c);
    return wide[31:0];
  endfunction

  // Bounded integer: scaling for powers of two, else modulo with rejection.
  function automatic logic [31:0] bounded_draw(bit backward, logic [31:0] lim);
    logic [31:0] j;
    logic [31:0] k;
    logic [63:0] prod;
    if (lim[31] || lim == 32'd0)
      return lim;
    if ((lim & (32'd0 - lim)) == lim) begin
      j = step_draw(backward, 31);
      prod = {32'b0, lim} * {32'b0, j};
      return prod[62:31];
    end
    k = 32'd0;
    for (int n = 0; n < DRAW_LIMIT; n++) begin
      j = step_draw(backward, 31) & 32'h7FFF_FFFF;
      k = j % lim;
      if (((j - k + (lim - 32'd1)) & 32'h8000_0000) == 32'd0)
        break;
    end
    return k;
  endfunction

  function automatic logic [63:0] sign_extend(logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [63:0] predict_result(logic [2:0] op, logic [47:0] sv,
                                                 logic [5:0] cnt, logic [31:0] lim);
    logic [31:0] hi;
    logic [31:0] lo;
    case (op)
      OP_SEED_MIX: begin
        pred_seed = sv ^ pred_mult;
        return 64'd0;
      end
      OP_SEED_RAW: begin
        pred_seed = sv;
        return 64'd0;
      end
      OP_NEXT_BITS: return sign_extend(step_draw(1'b0, cnt));
      OP_PREV_BITS: return sign_extend(step_draw(1'b1, cnt));
      OP_NEXT_BND:  return sign_extend(bounded_draw(1'b0, lim));
      OP_PREV_BND:  return sign_extend(bounded_draw(1'b1, lim));
      OP_NEXT_LONG: begin
        hi = step_draw(1'b0, 32);
        lo = step_draw(1'b0, 32);
        return {hi, 32'b0} + sign_extend(lo);
      end
      default: return 64'd0;
    endcase
  endfunction

  // Inverse of an odd multiplier modulo 2^48 by Newton iteration.
  function automatic logic [47:0] odd_inverse(logic [47:0] m);
    logic [47:0] x;
    x = m;
    for (int n = 0; n < 6; n++)
      x = x * (48'd2 - m * x);
    return x;
  endfunction

  // Sender: one transfer on the input channel, with a random gap before it.
  task automatic send_item(logic [2:0] op, logic [47:0] sv, logic [5:0] cnt,
                           logic [31:0] lim);
    int gap;
    gap = gaps_on ? $urandom_range(0, 19) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    seed_value <= sv;
    bit_count  <= cnt;
    limit      <= lim;
    do @(posedge clk); while (!(in_valid && in_ready));
    expected_values.push_back(predict_result(op, sv, cnt, lim));
  endtask

  // Drop valid and wait until every expected result has been transferred.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [47:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_MULT: pred_mult = data;
      REG_INC:  pred_inc  = data;
      REG_INV:  pred_inv  = data;
      default: ;
    endcase
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  // Limits biased toward the interesting classes.
  function automatic logic [31:0] rand_limit();
    case ($urandom_range(0, 7))
      0: return 32'd1 << $urandom_range(0, 30);
      1: return $urandom_range(1, 100);
      2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      3: return 32'h4000_0001 + $urandom_range(0, 1000);
      4: return {1'b1, 31'($urandom)};
      5: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_item();
    logic [2:0] op;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8)       op = OP_SEED_MIX;
    else if (pick < 14) op = OP_SEED_RAW;
    else if (pick < 32) op = OP_NEXT_BITS;
    else if (pick < 48) op = OP_PREV_BITS;
    else if (pick < 66) op = OP_NEXT_BND;
    else if (pick < 82) op = OP_PREV_BND;
    else if (pick < 97) op = OP_NEXT_LONG;
    else                op = OP_UNUSED;
    send_item(op, rand48(),
              ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(1, 32)),
              rand_limit());
  endtask

  // Directed: every operation with field extremes and the special cases.
  task automatic test_directed();
    send_item(OP_NEXT_BITS, 48'd0, 6'd32, 32'd0);
    send_item(OP_SEED_MIX, 48'hFFFF_FFFF_FFFF, 6'd1, 32'd0);
    send_item(OP_NEXT_BITS, 48'd0, 6'd1, 32'd0);
    send_item(OP_PREV_BITS, 48'd0, 6'd32, 32'd0);
    send_item(OP_SEED_RAW, 48'h1234_5678_9ABC, 6'd0, 32'd0);
    // Bit count of zero, and counts above 32 that clamp.
    send_item(OP_NEXT_BITS, 48'd0, 6'd0, 32'd0);
    send_item(OP_NEXT_BITS, 48'd0, 6'd33, 32'd0);
    send_item(OP_PREV_BITS, 48'd0, 6'd63, 32'd0);
    // Non-positive limits come back unchanged.
    send_item(OP_NEXT_BND, 48'd0, 6'd31, 32'd0);
    send_item(OP_PREV_BND, 48'd0, 6'd31, 32'h8000_0000);
    send_item(OP_NEXT_BND, 48'd0, 6'd31, 32'hFFFF_FFFF);
    // Powers of two, the extremes among them.
    send_item(OP_NEXT_BND, 48'd0, 6'd31, 32'd1);
    send_item(OP_PREV_BND, 48'd0, 6'd31, 32'h4000_0000);
    send_item(OP_NEXT_BND, 48'd0, 6'd31, 32'd16);
    // Other limits, where large ones force rejection redraws.
    send_item(OP_NEXT_BND, 48'd0, 6'd31, 32'd3);
    send_item(OP_NEXT_BND, 48'd0, 6'd31, 32'h7FFF_FFFF);
    send_item(OP_PREV_BND, 48'd0, 6'd31, 32'h4000_0001);
    send_item(OP_NEXT_LONG, 48'd0, 6'd0, 32'd0);
    send_item(OP_SEED_RAW, 48'hFFFF_FFFF_FFFF, 6'd63, 32'hFFFF_FFFF);
    send_item(OP_NEXT_LONG, 48'd0, 6'd0, 32'd0);
    send_item(OP_UNUSED, 48'hFFFF_FFFF_FFFF, 6'd63, 32'hFFFF_FFFF);
    wait_drained();
  endtask

  // Register settings, extremes among them; few items where redraws run long.
  task automatic test_register_settings();
    logic [47:0] m;
    write_reg(REG_MULT, 48'd0);
    write_reg(REG_INC, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_INV, 48'hFFFF_FFFF_FFFF);
    repeat (20) send_random_item();
    wait_drained();
    write_reg(REG_MULT, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_INC, 48'd0);
    write_reg(REG_INV, 48'd0);
    repeat (20) send_random_item();
    wait_drained();
    for (int s = 0; s < 4; s++) begin
      m = rand48() | 48'd1;
      write_reg(REG_MULT, m);
      write_reg(REG_INC, rand48());
      write_reg(REG_INV, odd_inverse(m));
      repeat (40) send_random_item();
      wait_drained();
    end
    write_reg(REG_MULT, MULT_RESET);
    write_reg(REG_INC, INC_RESET);
    write_reg(REG_INV, INV_RESET);
  endtask

  // Mostly seed-then-walk sequences with random content.
  task automatic test_random(int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 4) != 0) begin
        send_item($urandom_range(0, 1) ? OP_SEED_MIX : OP_SEED_RAW, rand48(), 6'd0, 32'd0);
        sent++;
        repeat ($urandom_range(3, 12)) begin
          send_random_item();
          sent++;
        end
      end else begin
        send_random_item();
        sent++;
      end
    end
  endtask

  // Receiver holds off while the sender keeps offering back to back.
  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_request = 1'b1;
    repeat (12) send_random_item();
    gaps_on = 1'b1;
    wait_drained();
  endtask

  // Receiver: random stalls, plus a long hold-off when asked.
  initial begin
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      int stall;
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  // Compare each output transfer against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_values.size() == 0) begin
        $error("unexpected result_value %0d", result_value);
        error_count++;
      end else begin
        if (result_value !== expected_values[0]) begin
          $error("result_value: expected %0d, actual %0d", expected_values[0], result_value);
          error_count++;
        end
        void'(expected_values.pop_front());
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    operation = '0;
    seed_value = '0;
    bit_count = '0;
    limit = '0;
    error_count = 0;
    cycle_count = 0;
    gaps_on = 1'b1;
    hold_request = 1'b0;
    pred_seed = '0;
    pred_mult = MULT_RESET;
    pred_inc = INC_RESET;
    pred_inv = INV_RESET;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_register_settings();
    test_random(500);
    // Sender pauses until every result has come, then resumes.
    wait_drained();
    test_backpressure();
    test_random(600);
    // Stretch with no idling on the sender side.
    gaps_on = 1'b0;
    test_random(60);
    gaps_on = 1'b1;

    wait_drained();
    repeat (60) @(posedge clk);
    if (error_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
